FILE: rtl/fblp_pkg.sv
// Shared constants and command codes for the page framebuffer line plotter.
`timescale 1ns / 1ps

package fblp_pkg;

  localparam int COLUMNS = 128;  // byte columns per page
  localparam int PAGES   = 8;    // pages of eight pixel rows
  localparam int FUNC_W  = 2;
  localparam int X_W     = 7;
  localparam int Y_W     = 6;
  localparam int DATA_W  = 8;    // one byte holds eight vertical pixels

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DRAW  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

endpackage

FILE: rtl/fblp_store.sv
// Pixel store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module fblp_store #(
  parameter int Depth = fblp_pkg::COLUMNS * fblp_pkg::PAGES,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [fblp_pkg::DATA_W-1:0] wr_data_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [fblp_pkg::DATA_W-1:0] rd_data_o
);

  logic [fblp_pkg::DATA_W-1:0] mem_q [Depth];
  logic [fblp_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/framebuffer_line_plotter_top.sv
// Top level of the page framebuffer line plotter: command sequencer and result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// command   in         in_valid_i/in_stall_o  func_i, x_a_i, y_a_i, x_b_i, y_b_i
// result    out        out_valid_o/out_stall_i read_data_o
//
// Every command beat gives one result beat (read byte, or zero).
// Draw: sloped lines first run the divider steps, then walk the plotted columns;
// vertical lines skip the divider and walk the plotted rows.
// Each pixel is a read-modify-write on the single store port pair.
// Clear: one byte zeroed per cycle. Read: one pixel byte is read and returned.
// After reset the same clearing pass runs before the first command beat is taken.
// A stalled result holds the sequencer in its final state; the output register
// frees the command side once it drains.

module framebuffer_line_plotter_top #(
  parameter int COLUMNS = fblp_pkg::COLUMNS,
  parameter int PAGES   = fblp_pkg::PAGES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fblp_pkg::FUNC_W-1:0] func_i,
  input  logic [fblp_pkg::X_W-1:0]    x_a_i,
  input  logic [fblp_pkg::Y_W-1:0]    y_a_i,
  input  logic [fblp_pkg::X_W-1:0]    x_b_i,
  input  logic [fblp_pkg::Y_W-1:0]    y_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fblp_pkg::DATA_W-1:0] read_data_o
);

  localparam int Depth = COLUMNS * PAGES;
  localparam int AddrW = $clog2(Depth);
  localparam int XW    = fblp_pkg::X_W;
  localparam int YW    = fblp_pkg::Y_W;
  localparam int DW    = fblp_pkg::DATA_W;
  localparam int DivW  = $clog2(YW);

  typedef enum logic [2:0] {
    S_INIT,   // clearing pass after reset
    S_IDLE,
    S_DIV,    // split |dy| into whole step and remainder step
    S_RD,     // issue the read of one pixel byte
    S_WR,     // merge the pixel and write back, advance
    S_CLEAR,  // zero sweep for the clear command
    S_DONE    // hand the result to the output register
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] clr_q;
  logic [DivW-1:0]  div_cnt_q;
  logic             out_valid_q;
  logic [DW-1:0]    read_data_q;

  // Line walker datapath
  logic [XW-1:0] x_q, x_end_q, span_q;
  logic [YW-1:0] y_q, y_end_q, q_q, a_q, dvd_q;
  logic [XW-1:0] r_q, b_q;
  logic          up_q, vert_q, rd_op_q;
  logic [DW-1:0] res_q;

  // Store ports
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [DW-1:0]    wr_data;
  logic [AddrW-1:0] pix_addr;
  logic [DW-1:0]    rd_data;

  // Current pixel
  logic [YW-1:0] row;
  logic [2:0]    pg;
  logic          in_range;
  logic [DW-1:0] mask;

  // Command decode
  logic          accept;
  logic          swap;
  logic [XW-1:0] x1, x2;
  logic [YW-1:0] y1, y2, dy;
  logic          out_free;
  logic          walk_done;
  logic [XW:0]   div_trial;
  logic          div_bit;
  logic [XW:0]   r_sum;
  logic          r_wrap;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    swap = (x_a_i > x_b_i);
    x1   = swap ? x_b_i : x_a_i;
    x2   = swap ? x_a_i : x_b_i;
    y1   = swap ? y_b_i : y_a_i;
    y2   = swap ? y_a_i : y_b_i;
    dy   = (y2 > y1) ? (y2 - y1) : (y1 - y2);
  end

  // Row of the current pixel: base row plus or minus the accumulated offset
  always_comb begin
    if (vert_q) begin
      row = y_q;
    end else if (up_q) begin
      row = y_q + q_q;
    end else begin
      row = y_q - q_q;
    end
    pg       = row[YW-1:3];
    in_range = ({2'b00, x_q} < 9'(COLUMNS)) && ({2'b00, pg} < 5'(PAGES));
    mask     = DW'(1) << row[2:0];
    pix_addr = AddrW'(32'(pg) * 32'(COLUMNS) + 32'(x_q));
  end

  assign walk_done = vert_q ? (y_q == y_end_q) : (x_q == x_end_q);

  // One restoring-division step per cycle; b_q carries the partial remainder
  assign div_trial = {b_q, dvd_q[YW-1]};
  assign div_bit   = (div_trial >= {1'b0, span_q});

  // Remainder accumulator for the next column
  assign r_sum  = {1'b0, r_q} + {1'b0, b_q};
  assign r_wrap = (r_sum >= {1'b0, span_q});

  // Store write mux: sweeps write zero, pixels OR into the byte just read
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pix_addr;
    wr_data = rd_data | mask;
    case (state_q)
      S_INIT, S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      S_WR: begin
        wr_en = !rd_op_q && in_range;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  fblp_store #(
    .Depth(Depth)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(pix_addr),
    .rd_data_o(rd_data)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      read_data_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          if (clr_q == AddrW'(Depth - 1)) begin
            clr_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + AddrW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            div_cnt_q <= '0;
            case (fblp_pkg::func_e'(func_i))
              fblp_pkg::FUNC_DRAW:  state_q <= (x1 == x2) ? S_RD : S_DIV;
              fblp_pkg::FUNC_CLEAR: state_q <= S_CLEAR;
              fblp_pkg::FUNC_READ:  state_q <= S_RD;
              default:              state_q <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q + DivW'(1);
          if (div_cnt_q == DivW'(YW - 1)) begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_WR;
        end
        S_WR: begin
          state_q <= walk_done ? S_DONE : S_RD;
        end
        S_CLEAR: begin
          if (clr_q == AddrW'(Depth - 1)) begin
            clr_q   <= '0;
            state_q <= S_DONE;
          end else begin
            clr_q <= clr_q + AddrW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            read_data_q <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Walker datapath: endpoints, divider, column stepping
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_q   <= '0;
          rd_op_q <= (func_i == fblp_pkg::FUNC_READ);
          r_q     <= '0;
          q_q     <= '0;
          b_q     <= '0;
          a_q     <= '0;
          dvd_q   <= dy;
          span_q  <= x2 - x1;
          up_q    <= (y2 > y1);
          x_end_q <= x2;
          if (func_i == fblp_pkg::FUNC_READ) begin
            vert_q  <= 1'b1;
            x_q     <= x_a_i;
            y_q     <= y_a_i;
            y_end_q <= y_a_i;
          end else if (x1 == x2) begin
            // vertical run: walk rows low to high in one column
            vert_q  <= 1'b1;
            x_q     <= x1;
            y_q     <= (y1 < y2) ? y1 : y2;
            y_end_q <= (y1 < y2) ? y2 : y1;
          end else begin
            vert_q  <= 1'b0;
            x_q     <= x1;
            y_q     <= y1;
            y_end_q <= y2;
          end
        end
      end
      S_DIV: begin
        dvd_q <= dvd_q << 1;
        a_q   <= {a_q[YW-2:0], div_bit};
        b_q   <= div_bit ? XW'(div_trial - {1'b0, span_q}) : XW'(div_trial);
      end
      S_WR: begin
        if (rd_op_q) begin
          res_q <= in_range ? rd_data : '0;
        end
        if (vert_q) begin
          y_q <= y_q + YW'(1);
        end else begin
          x_q <= x_q + XW'(1);
          if (r_wrap) begin
            r_q <= XW'(r_sum - {1'b0, span_q});
            q_q <= q_q + a_q + YW'(1);
          end else begin
            r_q <= XW'(r_sum);
            q_q <= q_q + a_q;
          end
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

`ifndef SYNTHESIS
  // Store writes only come from the sweeps and the write-back step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_INIT || state_q == S_CLEAR || state_q == S_WR))
    else $error("store write outside a write state");

  // A taken command always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("command accepted but sequencer stayed idle");

  // The column remainder stays below the span while walking a sloped line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD && !vert_q) |-> (r_q < span_q))
    else $error("line remainder out of range");

  // A result appears only from the final state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside the final state");
`endif

endmodule

FILE: sim/framebuffer_line_plotter_top_test.sv
// Self-checking testbench for the page framebuffer line plotter.
`timescale 1ns / 1ps

module framebuffer_line_plotter_top_test;

  // Approximate count of command beats to send; the directed part is included.
  localparam int ITEMS = 1900;
  localparam int FW    = fblp_pkg::FUNC_W;
  localparam int XW    = fblp_pkg::X_W;
  localparam int YW    = fblp_pkg::Y_W;
  localparam int DW    = fblp_pkg::DATA_W;
  // The 2-bit command field has one code that the package does not name.
  localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;
  // Cycles to watch for stray result beats once everything has drained.
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [FW-1:0] func;
    logic [XW-1:0] xa;
    logic [YW-1:0] ya;
    logic [XW-1:0] xb;
    logic [YW-1:0] yb;
  } cmd_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [FW-1:0] func;
  logic [XW-1:0] x_a;
  logic [YW-1:0] y_a;
  logic [XW-1:0] x_b;
  logic [YW-1:0] y_b;
  logic          out_valid;
  logic          out_stall;
  logic [DW-1:0] read_data;

  // Pending command beats (filled up front), bytes the plotter owes us, and
  // our own copy of the pixel store.
  cmd_t          cmd_backlog[$];
  logic [DW-1:0] owed_bytes[$];
  logic [DW-1:0] pixel_model[fblp_pkg::PAGES*fblp_pkg::COLUMNS];
  cmd_t          next_cmd;

  int n_issued   = 0;
  int n_accepted = 0;
  int n_fail     = 0;
  int send_idle_pct;
  int recv_idle_pct;

  framebuffer_line_plotter_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .func_i     (func),
    .x_a_i      (x_a),
    .y_a_i      (y_a),
    .x_b_i      (x_b),
    .y_b_i      (y_b),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .read_data_o(read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle schedule: sender light / receiver heavy for the first third, swapped
  // for the second third, then both sides run flat out.
  always_comb begin
    if (n_issued < ITEMS / 3) begin
      send_idle_pct = 24;
      recv_idle_pct = 59;
    end else if (n_issued < 2 * ITEMS / 3) begin
      send_idle_pct = 59;
      recv_idle_pct = 24;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // OR one pixel into the model; drop it when it falls outside the store.
  function automatic void plot_pixel(int x, int y);
    int idx;
    if (x < fblp_pkg::COLUMNS && (y >> 3) < fblp_pkg::PAGES) begin
      idx = (y >> 3) * fblp_pkg::COLUMNS + x;
      pixel_model[idx] = pixel_model[idx] | (8'd1 << (y & 7));
    end
  endfunction

  // Apply one accepted command to the model and return the byte it yields.
  function automatic logic [DW-1:0] apply_command(cmd_t c);
    int x1, y1, x2, y2, swap, x, y, span, lo, hi;
    logic [DW-1:0] data;
    data = '0;
    case (c.func)
      fblp_pkg::FUNC_DRAW: begin
        x1 = c.xa;
        y1 = c.ya;
        x2 = c.xb;
        y2 = c.yb;
        // Order the endpoints left to right.
        if (x1 > x2) begin
          swap = x1; x1 = x2; x2 = swap;
          swap = y1; y1 = y2; y2 = swap;
        end
        if (x1 != x2) begin
          // One pixel per column, row offset truncated toward the left row.
          span = x2 - x1;
          for (x = x1; x <= x2; x++) begin
            if (y2 > y1) plot_pixel(x, y1 + (y2 - y1) * (x - x1) / span);
            else         plot_pixel(x, y1 - (y1 - y2) * (x - x1) / span);
          end
        end else begin
          // Same column: fill every row between the endpoints.
          lo = (y1 < y2) ? y1 : y2;
          hi = (y1 < y2) ? y2 : y1;
          for (y = lo; y <= hi; y++) plot_pixel(x1, y);
        end
      end
      fblp_pkg::FUNC_CLEAR: begin
        foreach (pixel_model[i]) pixel_model[i] = '0;
      end
      fblp_pkg::FUNC_READ: begin
        if (c.xa < fblp_pkg::COLUMNS && (c.ya >> 3) < fblp_pkg::PAGES)
          data = pixel_model[(c.ya >> 3) * fblp_pkg::COLUMNS + c.xa];
      end
      default: ;  // unused code: store untouched, zero back
    endcase
    return data;
  endfunction

  task automatic queue_cmd(logic [FW-1:0] f, logic [XW-1:0] xa, logic [YW-1:0] ya,
                           logic [XW-1:0] xb, logic [YW-1:0] yb);
    cmd_backlog.push_back('{func: f, xa: xa, ya: ya, xb: xb, yb: yb});
  endtask

  task automatic report_mismatch(string what, logic [DW-1:0] want, logic [DW-1:0] got);
    $display("%0t: mismatch on %s: expected %02h, got %02h", $realtime, what, want, got);
    n_fail++;
  endtask

  // Command driver: predict on every accepted beat, then present the next one
  // (or go idle) whenever the port is free. Valid drops only when no beat
  // follows, so it gets a single assignment per edge.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      func     <= fblp_pkg::FUNC_DRAW;
      x_a      <= '0;
      y_a      <= '0;
      x_b      <= '0;
      y_b      <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_bytes.push_back(apply_command('{func: func, xa: x_a, ya: y_a, xb: x_b, yb: y_b}));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          func     <= next_cmd.func;
          x_a      <= next_cmd.xa;
          y_a      <= next_cmd.ya;
          x_b      <= next_cmd.xb;
          y_b      <= next_cmd.yb;
          n_issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted beat against the oldest owed byte,
  // then pick the stall for the next cycle.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_bytes.size() == 0) report_mismatch("result beat with nothing owed", '0, read_data);
        else if (read_data !== owed_bytes[0]) begin
          report_mismatch("read_data", owed_bytes[0], read_data);
          void'(owed_bytes.pop_front());
        end else begin
          void'(owed_bytes.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: far beyond the slowest legal run, including the power-up clear.
  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int r;
    logic [XW-1:0] xa, xb;
    logic [YW-1:0] ya, yb;

    rst_n = 1'b0;

    // The plotter clears its store at reset; start the model the same way.
    foreach (pixel_model[i]) pixel_model[i] = '0;

    // Directed: corners, both slope signs, swapped endpoints, vertical runs
    // in both directions, a single-pixel line, the unused code, and clear.
    queue_cmd(fblp_pkg::FUNC_READ,   0,   0,   0,  0);   // store starts cleared
    queue_cmd(fblp_pkg::FUNC_DRAW,   0,   0, 127, 63);
    queue_cmd(fblp_pkg::FUNC_READ, 127,  63,   0,  0);
    queue_cmd(fblp_pkg::FUNC_READ,  64,  31,   0,  0);
    queue_cmd(fblp_pkg::FUNC_DRAW, 127,   0,   0, 63);   // right-to-left, falling
    queue_cmd(fblp_pkg::FUNC_READ,   0,  63,   0,  0);
    queue_cmd(fblp_pkg::FUNC_DRAW,   5,  10,   5, 50);
    queue_cmd(fblp_pkg::FUNC_DRAW,   9,  50,   9, 10);
    queue_cmd(fblp_pkg::FUNC_DRAW,  20,  40,  20, 40);
    queue_cmd(fblp_pkg::FUNC_READ,   5,  16,   0,  0);
    queue_cmd(fblp_pkg::FUNC_READ,   9,  50,   0,  0);
    queue_cmd(fblp_pkg::FUNC_READ,  20,  40,   0,  0);
    queue_cmd(fblp_pkg::FUNC_DRAW,   0,  63, 127, 63);
    queue_cmd(fblp_pkg::FUNC_DRAW, 127,   0,   0,  0);
    queue_cmd(fblp_pkg::FUNC_READ, 127,   0,   0,  0);
    queue_cmd(FUNC_UNUSED,         127,  63, 127, 63);
    queue_cmd(fblp_pkg::FUNC_READ, 127,  63, 127, 63);
    queue_cmd(fblp_pkg::FUNC_CLEAR, 127, 63, 127, 63);
    queue_cmd(fblp_pkg::FUNC_READ, 127,  63,   0,  0);
    queue_cmd(fblp_pkg::FUNC_READ,   0,   0,   0,  0);
    queue_cmd(fblp_pkg::FUNC_DRAW,   1,  62, 126,  1);
    queue_cmd(fblp_pkg::FUNC_READ, 126,   1,   0,  0);
    queue_cmd(fblp_pkg::FUNC_DRAW,   0,   0,   1, 63);   // steep, two columns only
    queue_cmd(fblp_pkg::FUNC_READ,   1,  63,   0,  0);

    // Random: mostly lines followed by a read on one of their endpoints so
    // reads come back nonzero, plus stray reads, rare clears, unused codes.
    while (cmd_backlog.size() < ITEMS) begin
      r  = $urandom_range(99);
      xa = XW'($urandom_range(127));
      ya = YW'($urandom_range(63));
      xb = XW'($urandom_range(127));
      yb = YW'($urandom_range(63));
      if (r < 3) begin
        queue_cmd(fblp_pkg::FUNC_CLEAR, xa, ya, xb, yb);
      end else if (r < 6) begin
        queue_cmd(FUNC_UNUSED, xa, ya, xb, yb);
      end else if (r < 56) begin
        case ($urandom_range(3))
          0: xb = xa;                                   // vertical run
          1: xb = XW'(xa + $urandom_range(6) - 3);      // short line, may wrap
          default: ;
        endcase
        queue_cmd(fblp_pkg::FUNC_DRAW, xa, ya, xb, yb);
        if ($urandom_range(99) < 60) begin
          if ($urandom_range(1) == 0) queue_cmd(fblp_pkg::FUNC_READ, xa, ya, xb, yb);
          else                        queue_cmd(fblp_pkg::FUNC_READ, xb, yb, xa, ya);
        end
      end else begin
        queue_cmd(fblp_pkg::FUNC_READ, xa, ya, xb, yb);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go in and every owed byte to come back, then
    // keep watching for stray result beats.
    while (n_accepted < n_issued || cmd_backlog.size() != 0 || in_valid)
      @(posedge clk);
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_fail == 0) $display("SUCCESS");
    else             $display("FAILURE");
    $finish;
  end

endmodule
